/* hw/rtl/nms3_pkg.sv */
// ----------------------------------------------------------------------------
// nms3_pkg
// Shared widths, register indexes and reset values for the 3x3 score
// window non-maximum suppression block.
// ----------------------------------------------------------------------------
package nms3_pkg;

    localparam int SCORE_W        = 16;
    localparam int CENTER_X_W     = 10;
    localparam int CENTER_Y_W     = 12;

    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int LINE_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam int LINE_WIDTH_RST   = 1024;
    localparam int FRAME_HEIGHT_RST = 1024;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    typedef logic [SCORE_W-1:0] t_score;

endpackage

/* hw/rtl/nms_3x3_score_window_core.sv */
// ----------------------------------------------------------------------------
// nms_3x3_score_window_core
// 3x3 non-maximum suppression over a raster stream of 16-bit scores.
// ----------------------------------------------------------------------------
// Pipeline: a request is taken into stage 1 as the line RAM is read, then
//   passes to the output register with the window shift and compare.
// Throughput: one request per cycle, set by one read and one write of the
//   line RAM each cycle; output backpressure stalls the two stages.
// Reset: synchronous, active low; counters, window and delay lines clear,
//   and the line RAM reads as zero until each column is first written.
// ----------------------------------------------------------------------------
module nms_3x3_score_window_core
    import nms3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SCORE_W-1:0]    i_score,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_peak,
    output logic [CENTER_X_W-1:0] o_center_x,
    output logic [CENTER_Y_W-1:0] o_center_y
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int RST_W = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;
    localparam int RST_H = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    // configuration: last column / last row, already saturated
    logic [AW-1:0] r_wlast, n_wlast;
    logic [HW-1:0] r_hlast, n_hlast;
    int            lw_i, fh_i;
    logic          cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        lw_i = int'(i_cfg_data[LINE_WIDTH_W-1:0]);
        fh_i = int'(i_cfg_data[FRAME_HEIGHT_W-1:0]);
        if (lw_i < 3) lw_i = 3;
        if (lw_i > MAX_WIDTH) lw_i = MAX_WIDTH;
        if (fh_i < 3) fh_i = 3;
        if (fh_i > MAX_HEIGHT) fh_i = MAX_HEIGHT;
        n_wlast = AW'(lw_i - 1);
        n_hlast = HW'(fh_i - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= AW'(RST_W - 1);
            r_hlast <= HW'(RST_H - 1);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_wlast <= n_wlast;
                CFG_FRAME_HEIGHT: r_hlast <= n_hlast;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic in_acc, adv1;
    logic r_v1;
    logic r_ov;

    assign adv1    = r_v1 && (!r_ov || i_ready);
    assign o_ready = !r_v1 || adv1;
    assign in_acc  = i_valid && o_ready;

    // counters and coordinate delay lines, stepped on each request
    logic [AW-1:0] r_col, r_xh0;
    logic [HW-1:0] r_row, r_yh0, r_yh1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_xh0 <= '0;
            r_yh0 <= '0;
            r_yh1 <= '0;
        end else if (in_acc) begin
            r_xh0 <= r_col;
            r_yh1 <= r_yh0;
            if (r_col >= r_wlast) begin
                r_col <= '0;
                r_yh0 <= r_row;
                r_row <= (r_row >= r_hlast) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage 1: RAM data arrives, window shifts, RAM entry written back
    t_score        r_s1;
    logic [AW-1:0] r_col1, r_x1;
    logic [HW-1:0] r_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_acc) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1   <= i_score;
            r_col1 <= r_col;
            r_x1   <= r_xh0;
            r_y1   <= r_yh1;
        end
    end

    logic [2*SCORE_W-1:0] rd_data;
    t_score               up1, up2;
    logic                 corner;

    // word layout: upper half two rows up, lower half one row up
    assign up2 = rd_data[2*SCORE_W-1:SCORE_W];
    assign up1 = rd_data[SCORE_W-1:0];

    nms3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * SCORE_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (adv1),
        .i_wr_addr (r_col1),
        .i_wr_data ({up1, r_s1}),
        .o_rd_data (rd_data)
    );

    nms3_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (adv1),
        .i_cur    (r_s1),
        .i_up1    (up1),
        .i_up2    (up2),
        .o_corner (corner)
    );

    // output register
    logic                  r_corner;
    logic [CENTER_X_W-1:0] r_cx;
    logic [CENTER_Y_W-1:0] r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv1) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_corner <= corner;
            r_cx     <= CENTER_X_W'(r_x1);
            r_cy     <= CENTER_Y_W'(r_y1);
        end
    end

    assign o_valid    = r_ov;
    assign o_peak     = r_corner;
    assign o_center_x = r_cx;
    assign o_center_y = r_cy;

    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && adv1 |-> r_col != r_col1)
        else $error("line RAM read and write hit the same column");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !adv1 |=> r_v1 && $stable(r_col1) && $stable(r_s1))
        else $error("stage 1 request lost under stall");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 |=> o_valid)
        else $error("advanced request did not reach the output register");

    a_wrap_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_col >= r_wlast |=> r_col == '0)
        else $error("column counter failed to wrap");

endmodule

/* hw/rtl/nms3_line_buf.sv */
// ----------------------------------------------------------------------------
// nms3_line_buf
// Line store RAM holding the two previous rows side by side in one word.
// A fill count marks the written prefix; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module nms3_line_buf
    import nms3_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int DW    = 2 * SCORE_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    output logic [DW-1:0]            o_rd_data
);

    localparam int FW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          r_rd_ok;
    logic [FW-1:0] r_fill;

    // columns are visited in order from zero, so the written set is a prefix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_ok <= FW'(i_rd_addr) < r_fill;
            if (FW'(i_rd_addr) == r_fill) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("line buffer fill count beyond depth");

    a_rd_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> FW'(i_rd_addr) <= r_fill)
        else $error("line buffer read skips past the written prefix");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en && FW'(i_rd_addr) == r_fill |=> r_fill == $past(r_fill) + 1'b1)
        else $error("line buffer fill count did not advance");

endmodule

/* hw/rtl/nms3_window.sv */
// ----------------------------------------------------------------------------
// nms3_window
// 3x3 score window: two stored columns plus the incoming column, and the
// strict-maximum test of the centre against its eight neighbours.
// ----------------------------------------------------------------------------
module nms3_window
    import nms3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_score i_cur,
    input  t_score i_up1,
    input  t_score i_up2,
    output logic   o_corner
);

    // index 0 = current row, 1 = row above, 2 = two rows above
    t_score r_col0 [3];
    t_score r_col1 [3];
    t_score ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_col0[r] <= '0;
                r_col1[r] <= '0;
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_col1[r] <= r_col0[r];
            end
            r_col0[0] <= i_cur;
            r_col0[1] <= i_up1;
            r_col0[2] <= i_up2;
        end
    end

    // evaluated on the window as it stands after this shift
    always_comb begin
        ctr      = r_col0[1];
        o_corner = (i_cur     < ctr) && (r_col0[0] < ctr) && (r_col1[0] < ctr) &&
                   (i_up1     < ctr) && (r_col1[1] < ctr) &&
                   (i_up2     < ctr) && (r_col0[2] < ctr) && (r_col1[2] < ctr);
    end

endmodule

/* bench/nms_3x3_score_window_core_tb.sv */
// ----------------------------------------------------------------------------
// nms_3x3_score_window_core_tb
// Streams raster scores through the 3x3 non-maximum suppression core under
// random stalls on both sides. A scoreboard keeps its own line stores, window
// and coordinate delay lines, predicts flag and centre for every request, and
// checks each result in order. Width and height are reprogrammed before each
// batch of requests, including clamped, masked and unmapped register writes.
// ----------------------------------------------------------------------------
module nms_3x3_score_window_core_tb
    import nms3_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP      = CFG_IDX_W'(255);
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_CFGS    = 8;
    localparam int ITEMS_PER_CFG  = 52;

    typedef struct packed {
        logic                  peak;
        logic [CENTER_X_W-1:0] x;
        logic [CENTER_Y_W-1:0] y;
    } t_center_result;

    class corner_window_scoreboard;
        int unsigned    width_reg;
        int unsigned    height_reg;
        t_score         above1_line[MAX_WIDTH_DEF];
        t_score         above2_line[MAX_WIDTH_DEF];
        t_score         win[3][3];      // [row: 0 current, 1 up, 2 up2][col: 0 newest]
        int unsigned    col_pos;
        int unsigned    row_pos;
        int unsigned    x_hist[2];
        int unsigned    y_hist[3];
        t_center_result pending_centers[$];
        int             errors;

        function new();
            width_reg  = LINE_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (above1_line[i]) begin
                above1_line[i] = '0;
                above2_line[i] = '0;
            end
            foreach (win[r, c]) win[r][c] = '0;
            col_pos = 0;
            row_pos = 0;
            x_hist  = '{0, 0};
            y_hist  = '{0, 0, 0};
            errors  = 0;
        endfunction

        function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LINE_WIDTH)
                width_reg = data[LINE_WIDTH_W-1:0];
            else if (idx == CFG_FRAME_HEIGHT)
                height_reg = data[FRAME_HEIGHT_W-1:0];
        endfunction

        function void note_score(t_score s);
            int unsigned    w;
            int unsigned    h;
            t_score         up1;
            t_score         up2;
            t_score         ctr;
            t_center_result res;
            w = sat(width_reg, 3, MAX_WIDTH_DEF);
            h = sat(height_reg, 3, MAX_HEIGHT_DEF);

            up2 = above2_line[col_pos];
            up1 = above1_line[col_pos];
            above2_line[col_pos] = up1;
            above1_line[col_pos] = s;

            for (int r = 0; r < 3; r++) begin
                win[r][2] = win[r][1];
                win[r][1] = win[r][0];
            end
            win[0][0] = s;
            win[1][0] = up1;
            win[2][0] = up2;

            ctr = win[1][1];
            res.peak = win[0][0] < ctr && win[0][1] < ctr && win[0][2] < ctr &&
                       win[1][0] < ctr && win[1][2] < ctr &&
                       win[2][0] < ctr && win[2][1] < ctr && win[2][2] < ctr;

            // the newest row entry is only loaded on the last pixel of a row
            x_hist[1] = x_hist[0];
            x_hist[0] = col_pos;
            y_hist[2] = y_hist[1];
            y_hist[1] = y_hist[0];
            if (col_pos >= w - 1) begin
                col_pos   = 0;
                y_hist[0] = row_pos;
                if (row_pos >= h - 1) row_pos = 0;
                else                  row_pos++;
            end else begin
                col_pos++;
            end

            res.x = CENTER_X_W'(x_hist[1]);
            res.y = CENTER_Y_W'(y_hist[2]);
            pending_centers.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic c, logic [CENTER_X_W-1:0] x,
                          logic [CENTER_Y_W-1:0] y);
            t_center_result want;
            if (pending_centers.size() == 0) begin
                report($sformatf("unexpected result peak=%0b x=%0d y=%0d", c, x, y));
                return;
            end
            want = pending_centers.pop_front();
            if (c !== want.peak)
                report($sformatf("peak got %0b want %0b (x=%0d y=%0d)",
                                 c, want.peak, want.x, want.y));
            if (x !== want.x)
                report($sformatf("center_x got %0d want %0d", x, want.x));
            if (y !== want.y)
                report($sformatf("center_y got %0d want %0d", y, want.y));
        endtask

        function int pending();
            return pending_centers.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [SCORE_W-1:0]    i_score;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_peak;
    logic [CENTER_X_W-1:0] o_center_x;
    logic [CENTER_Y_W-1:0] o_center_y;

    corner_window_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_start = 0;
    int idle_cycles = 0;

    nms_3x3_score_window_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_score     (i_score),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_peak      (o_peak),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int stall_seen;
        int stall_left;
        stall_seen = 0;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_start != stall_seen) begin
                stall_seen = stall_start;
                stall_left = RX_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_peak, o_center_x, o_center_y);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_score(input t_score s);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_score = s;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        sb.note_score(s);
    endtask

    // leaves the bench at a falling edge with nothing in flight
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_score pick_score();
        case ($urandom_range(9))
            0, 1, 2, 3: return t_score'($urandom_range(65535));
            4, 5:       return t_score'($urandom_range(3));     // lots of ties
            6:          return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            7, 8:       return t_score'($urandom_range(255));
            default:    return 16'hFF00 | t_score'($urandom_range(255));
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] cfg_w[RANDOM_CFGS];
        logic [CFG_DATA_W-1:0] cfg_h[RANDOM_CFGS];
        t_score                peak_frame[12];

        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_score     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: score extremes at the reset geometry
        send_score(16'h0000);
        send_score(16'hFFFF);
        send_score(16'h0001);
        send_score(16'hFFFE);
        send_score(16'h8000);
        send_score(16'h7FFF);

        // shrink mid-row: column counter already past the new width
        write_reg(CFG_IDX_UNMAPPED, 16'h0005);
        write_reg(CFG_IDX_TOP, 16'hFFFF);
        write_reg(CFG_LINE_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd3);

        // single isolated peak, then one more row to bring it to the centre
        peak_frame = '{16'd10, 16'd20, 16'd30, 16'd40, 16'd60000, 16'd50,
                       16'd70, 16'd80, 16'd90, 16'd1, 16'd2, 16'd3};
        foreach (peak_frame[i]) send_score(peak_frame[i]);
        // flat plateau: equal neighbours never make a corner
        repeat (6) send_score(16'd500);

        cfg_w = '{16'd3, 16'd4, 16'd0, 16'd17, 16'hFFFF, 16'd1024, 16'd1025, 16'd7};
        cfg_h = '{16'd3, 16'd5, 16'd0, 16'd6,  16'hFFFF, 16'd4096, 16'd4097, 16'h2003};

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 68 : 0;
            rx_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 10 : 0;
            for (int k = 0; k < RANDOM_CFGS; k++) begin
                write_reg(CFG_LINE_WIDTH, cfg_w[(k + phase) % RANDOM_CFGS]);
                write_reg(CFG_FRAME_HEIGHT, cfg_h[(k + 2 * phase) % RANDOM_CFGS]);
                for (int n = 0; n < ITEMS_PER_CFG; n++) begin
                    if (phase == 2 && k == 0 && n == 10) stall_start++;
                    if (phase == 2 && k == 1 && n == 26) wait_drained();
                    send_score(pick_score());
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
